// ----- design/pfm_pkg.sv -----
// Package for the PID front-panel menu: field and button codes, state and
// result structs, and the percent/raw conversion constants.
// No dependencies; used by the interfaces, the menu core and the top level.
package pfm_pkg;

  // Full-scale raw count of the loop's setpoint and drive
  localparam int unsigned FULL_SCALE = 1023;

  localparam int unsigned RAW_W = 10;
  localparam int unsigned PCT_W = 7;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [RAW_W-1:0] RAW_MAX = 10'd1023;

  // Button codes
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_UP    = 2'd1;
  localparam logic [1:0] BTN_ENTER = 2'd2;
  localparam logic [1:0] BTN_DOWN  = 2'd3;

  // Menu field codes
  localparam logic [1:0] FIELD_ONOFF    = 2'd0;
  localparam logic [1:0] FIELD_MODE     = 2'd1;
  localparam logic [1:0] FIELD_SETPOINT = 2'd2;
  localparam logic [1:0] FIELD_DRIVE    = 2'd3;

  // Raw to percent: 100*r/FULL_SCALE by reciprocal multiply. With a
  // 28-bit fraction the rounding error stays below 1/FULL_SCALE for any
  // 10-bit raw value, so the truncated quotient is exact.
  localparam int unsigned RTP_SHIFT = 28;
  localparam longint unsigned RTP_MULT = ((64'd100 << RTP_SHIFT) / FULL_SCALE) + 64'd1;
  localparam int unsigned RTP_MULT_W = $clog2(RTP_MULT + 64'd1);
  localparam int unsigned RTP_PROD_W = RAW_W + RTP_MULT_W;

  // Percent to raw: FULL_SCALE*p/100, saturated, one entry per 7-bit code
  typedef logic [(1 << PCT_W)-1:0][RAW_W-1:0] p2r_lut_t;

  function automatic p2r_lut_t build_p2r_lut();
    p2r_lut_t lut;
    longint unsigned v;
    for (int i = 0; i < (1 << PCT_W); i++) begin
      v = (longint'(FULL_SCALE) * longint'(i)) / 100;
      lut[i] = (v > 64'd1023) ? RAW_MAX : RAW_W'(v);
    end
    return lut;
  endfunction

  localparam p2r_lut_t P2R_LUT = build_p2r_lut();

  // Menu state
  typedef struct packed {
    logic [1:0]       field_sel;
    logic             edit_flag;
    logic             pending_on;
    logic             pending_auto;
    logic             enabled;
    logic             auto_mode;
    logic [PCT_W-1:0] sp_pct;
    logic [PCT_W-1:0] drv_pct;
    logic [RAW_W-1:0] sp_value;
  } pfm_state_t;

  // One result per press
  typedef struct packed {
    logic [1:0]       selected_field;
    logic             editing;
    logic             controller_on;
    logic             auto_mode;
    logic [PCT_W-1:0] setpoint_percent;
    logic [PCT_W-1:0] drive_percent;
    logic [RAW_W-1:0] setpoint_raw;
    logic [RAW_W-1:0] drive_set;
    logic             drive_load;
  } pfm_result_t;

endpackage

// ----- design/pfm_if.sv -----
// Valid/ready channel interfaces for button-press requests and panel results.
// Depends on pfm_pkg for field widths.
interface pfm_press_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               button;
  logic [pfm_pkg::RAW_W-1:0] drive_now;

  modport source (output valid, output button, output drive_now, input ready);
  modport sink (input valid, input button, input drive_now, output ready);
endinterface

interface pfm_view_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               selected_field;
  logic                     editing;
  logic                     controller_on;
  logic                     auto_mode;
  logic [pfm_pkg::PCT_W-1:0] setpoint_percent;
  logic [pfm_pkg::PCT_W-1:0] drive_percent;
  logic [pfm_pkg::RAW_W-1:0] setpoint_raw;
  logic [pfm_pkg::RAW_W-1:0] drive_set;
  logic                     drive_load;

  modport source (output valid, output selected_field, output editing,
                  output controller_on, output auto_mode, output setpoint_percent,
                  output drive_percent, output setpoint_raw, output drive_set,
                  output drive_load, input ready);
  modport sink (input valid, input selected_field, input editing,
                input controller_on, input auto_mode, input setpoint_percent,
                input drive_percent, input setpoint_raw, input drive_set,
                input drive_load, output ready);
endinterface

// ----- design/pid_front_panel_menu_top.sv -----
// Top level of the PID front-panel menu: input register, menu state, result register.
// Depends on pfm_pkg, pfm_if.sv (pfm_press_if, pfm_view_if) and pfm_menu_core.
//
//   channel  dir  payload                                        accepted when
//   press    in   button[1:0], drive_now[9:0]                    valid & ready
//   view     out  selected_field .. drive_set[9:0], drive_load   valid & ready
//
// One press request per cycle while the result register is free or being read; its
// result moves from the input register to the result register and is valid there.
// The rate is set by the combinational menu update between the input register and
// the result register, which also writes the menu state.
// Synchronous reset clears the menu state and both valid flags.
// A stalled result holds in the result register; the input register keeps taking a
// request while the result register is free or being read.
module pid_front_panel_menu_top (
  input logic       clk,
  input logic       rst,
  pfm_press_if.sink press,
  pfm_view_if.source view
);

  logic                      s1_valid;
  logic [1:0]                s1_button;
  logic [pfm_pkg::RAW_W-1:0] s1_drive;
  pfm_pkg::pfm_state_t       state;
  pfm_pkg::pfm_state_t       state_next;
  pfm_pkg::pfm_result_t      res_next;
  logic                      out_valid;
  pfm_pkg::pfm_result_t      out_res;
  logic                      advance;

  // Pipeline flow: result register loads when free or being read
  assign advance     = s1_valid && (!out_valid || view.ready);
  assign press.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (press.ready) begin
      s1_valid <= press.valid;
    end
    if (press.ready && press.valid) begin
      s1_button <= press.button;
      s1_drive  <= press.drive_now;
    end
  end

  pfm_menu_core u_core (
    .button    (s1_button),
    .drive_now (s1_drive),
    .cur       (state),
    .nxt       (state_next),
    .res       (res_next)
  );

  // Menu state commits as the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (view.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign view.valid            = out_valid;
  assign view.selected_field   = out_res.selected_field;
  assign view.editing          = out_res.editing;
  assign view.controller_on    = out_res.controller_on;
  assign view.auto_mode        = out_res.auto_mode;
  assign view.setpoint_percent = out_res.setpoint_percent;
  assign view.drive_percent    = out_res.drive_percent;
  assign view.setpoint_raw     = out_res.setpoint_raw;
  assign view.drive_set        = out_res.drive_set;
  assign view.drive_load       = out_res.drive_load;

  // Percent values never pass full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    (state.sp_pct <= pfm_pkg::PCT_MAX) && (state.drv_pct <= pfm_pkg::PCT_MAX))
    else $error("menu percent above 100");

  // Setpoint is edited only in auto, drive only in manual
  a_edit_mode: assert property (@(posedge clk) disable iff (rst)
    state.edit_flag && (state.field_sel == pfm_pkg::FIELD_SETPOINT) |-> state.auto_mode)
    else $error("setpoint edit outside auto mode");

  a_drive_edit_mode: assert property (@(posedge clk) disable iff (rst)
    state.edit_flag && (state.field_sel == pfm_pkg::FIELD_DRIVE) |-> !state.auto_mode)
    else $error("drive edit outside manual mode");

  // A drive load is a commit on the drive field, back in view
  a_load_commit: assert property (@(posedge clk) disable iff (rst)
    view.valid && view.drive_load |->
      !view.editing && (view.selected_field == pfm_pkg::FIELD_DRIVE))
    else $error("drive load without drive commit");

  // No drive value without a load
  a_set_zero: assert property (@(posedge clk) disable iff (rst)
    view.valid && !view.drive_load |-> (view.drive_set == '0))
    else $error("drive_set nonzero without drive_load");

endmodule

// ----- design/pfm_menu_core.sv -----
// Combinational menu update: next state and panel result for one press.
// Depends on pfm_pkg (codes, structs, conversion constants).
module pfm_menu_core (
  input  logic [1:0]                button,
  input  logic [pfm_pkg::RAW_W-1:0] drive_now,
  input  pfm_pkg::pfm_state_t       cur,
  output pfm_pkg::pfm_state_t       nxt,
  output pfm_pkg::pfm_result_t      res
);

  logic                           rtp_sel_drive;
  logic [pfm_pkg::RAW_W-1:0]      rtp_raw;
  logic [pfm_pkg::RTP_PROD_W-1:0] rtp_prod;
  logic [pfm_pkg::RTP_PROD_W-1:0] rtp_quot;
  logic [pfm_pkg::PCT_W-1:0]      rtp_pct;
  logic [pfm_pkg::PCT_W-1:0]      p2r_idx;
  logic [pfm_pkg::RAW_W-1:0]      p2r_raw;
  logic [pfm_pkg::RAW_W-1:0]      dset;
  logic                           dload;

  function automatic logic [pfm_pkg::PCT_W-1:0] pct_up(input logic [pfm_pkg::PCT_W-1:0] p);
    return (p < pfm_pkg::PCT_MAX) ? p + 7'd1 : p;
  endfunction

  function automatic logic [pfm_pkg::PCT_W-1:0] pct_down(input logic [pfm_pkg::PCT_W-1:0] p);
    return (p != 7'd0) ? p - 7'd1 : p;
  endfunction

  // Raw to percent: drive_now going to manual, setpoint going to auto
  assign rtp_sel_drive = !cur.pending_auto;
  assign rtp_raw  = rtp_sel_drive ? drive_now : cur.sp_value;
  assign rtp_prod = pfm_pkg::RTP_PROD_W'(rtp_raw)
                  * pfm_pkg::RTP_PROD_W'(pfm_pkg::RTP_MULT);
  assign rtp_quot = rtp_prod >> pfm_pkg::RTP_SHIFT;
  assign rtp_pct  = (rtp_quot > pfm_pkg::RTP_PROD_W'(pfm_pkg::PCT_MAX))
                  ? pfm_pkg::PCT_MAX : rtp_quot[pfm_pkg::PCT_W-1:0];

  // Percent to raw for the field under edit
  assign p2r_idx = (cur.field_sel == pfm_pkg::FIELD_DRIVE) ? cur.drv_pct : cur.sp_pct;
  assign p2r_raw = pfm_pkg::P2R_LUT[p2r_idx];

  // Menu transitions
  always_comb begin
    nxt   = cur;
    dset  = '0;
    dload = 1'b0;
    if (button != pfm_pkg::BTN_NONE) begin
      if (!cur.edit_flag) begin
        // view: move selection or start an edit
        case (button)
          pfm_pkg::BTN_UP: begin
            if (cur.field_sel != pfm_pkg::FIELD_ONOFF) nxt.field_sel = cur.field_sel - 2'd1;
          end
          pfm_pkg::BTN_DOWN: begin
            if (cur.field_sel != pfm_pkg::FIELD_DRIVE) nxt.field_sel = cur.field_sel + 2'd1;
          end
          default: begin
            case (cur.field_sel)
              pfm_pkg::FIELD_ONOFF: begin
                nxt.pending_on = cur.enabled;
                nxt.edit_flag  = 1'b1;
              end
              pfm_pkg::FIELD_MODE: begin
                nxt.pending_auto = cur.auto_mode;
                nxt.edit_flag    = 1'b1;
              end
              pfm_pkg::FIELD_SETPOINT: begin
                if (cur.auto_mode) nxt.edit_flag = 1'b1;
              end
              default: begin
                if (!cur.auto_mode) nxt.edit_flag = 1'b1;
              end
            endcase
          end
        endcase
      end else begin
        // edit: change the pending value or commit it
        case (cur.field_sel)
          pfm_pkg::FIELD_ONOFF: begin
            case (button)
              pfm_pkg::BTN_UP:   nxt.pending_on = 1'b1;
              pfm_pkg::BTN_DOWN: nxt.pending_on = 1'b0;
              default: begin
                nxt.enabled   = cur.pending_on;
                nxt.edit_flag = 1'b0;
              end
            endcase
          end
          pfm_pkg::FIELD_MODE: begin
            case (button)
              pfm_pkg::BTN_UP:   nxt.pending_auto = 1'b0;
              pfm_pkg::BTN_DOWN: nxt.pending_auto = 1'b1;
              default: begin
                if (rtp_sel_drive) nxt.drv_pct = rtp_pct;
                else               nxt.sp_pct  = rtp_pct;
                nxt.auto_mode = cur.pending_auto;
                nxt.edit_flag = 1'b0;
              end
            endcase
          end
          pfm_pkg::FIELD_SETPOINT: begin
            case (button)
              pfm_pkg::BTN_UP:   nxt.sp_pct = pct_up(cur.sp_pct);
              pfm_pkg::BTN_DOWN: nxt.sp_pct = pct_down(cur.sp_pct);
              default: begin
                nxt.sp_value  = p2r_raw;
                nxt.edit_flag = 1'b0;
              end
            endcase
          end
          default: begin
            case (button)
              pfm_pkg::BTN_UP:   nxt.drv_pct = pct_up(cur.drv_pct);
              pfm_pkg::BTN_DOWN: nxt.drv_pct = pct_down(cur.drv_pct);
              default: begin
                dset          = p2r_raw;
                dload         = 1'b1;
                nxt.edit_flag = 1'b0;
              end
            endcase
          end
        endcase
      end
    end
  end

  // Result shows the state after the press
  assign res.selected_field   = nxt.field_sel;
  assign res.editing          = nxt.edit_flag;
  assign res.controller_on    = nxt.enabled;
  assign res.auto_mode        = nxt.auto_mode;
  assign res.setpoint_percent = nxt.sp_pct;
  assign res.drive_percent    = nxt.drv_pct;
  assign res.setpoint_raw     = nxt.sp_value;
  assign res.drive_set        = dset;
  assign res.drive_load       = dload;

endmodule
